// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/lqm_pkg.sv
// ---------------------------------------------------------------------------
// lqm_pkg
// Types, sizes and character helpers shared by the label/question matcher.
// ---------------------------------------------------------------------------
package lqm_pkg;

    localparam int ML  = 512;              // longest stored label
    localparam int CV  = 128;              // indexed character values
    localparam int QD  = ML + 2;           // question buffer depth
    localparam int PW  = $clog2(ML);       // label position
    localparam int LW  = $clog2(ML + 1);   // label length
    localparam int QAW = $clog2(QD);       // question address
    localparam int QW  = $clog2(QD + 1);   // question length
    localparam int CW  = $clog2(CV);       // character index

    localparam logic [7:0] SLASH = 8'd47;
    localparam logic [7:0] STAR  = 8'd42;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LBL_ACC,
        OP_Q_ACC,
        OP_LINK,
        OP_RD_Q0,
        OP_HEAD,
        OP_TAIL,
        OP_CHK,
        OP_INF,
        OP_SLASH,
        OP_FIRST,
        OP_WALK,
        OP_CMP_RD,
        OP_CMP_CHK,
        OP_NEXT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LINK,
        ST_START,
        ST_HEAD,
        ST_TAIL,
        ST_CHK,
        ST_INF,
        ST_SLASH,
        ST_FIRST,
        ST_WALK,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_NEXT
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   q_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic q_empty;
        logic q_star;
        logic n_one;
        logic n_gt_one;
        logic n_gt_len;
        logic prefix;
        logic suffix;
        logic q_high;
        logic q_slash;
        logic walk_stop;
        logic cmp_eq;
        logic cmp_last;
    } dp_status_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

endpackage

// File: rtl/label_question_matcher.sv
// ---------------------------------------------------------------------------
// label_question_matcher
// Wildcard match of a buffered question against a stored, indexed label.
// ---------------------------------------------------------------------------
//
//   channel   handshake          payload
//   --------  -----------------  ----------------------------
//   input     start / busy       req_type, ch, is_last
//   result    done (one cycle)   matched
//
// A label character is stored and looked up in the position table, then its
// chain link is inserted in ST_LINK. A question character is taken while idle;
// its last one starts the evaluation: setup, then a read and a check per compared
// byte and, in an infix walk, a step per chain position tried, all set by the
// single read port of each memory. busy falls in the cycle that done rises.
// Reset is asynchronous (rst_n low); memories hold no reset and need no
// clearing pass. done pulses for one cycle with matched and cannot be held off.
//
module label_question_matcher import lqm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       req_type,
    input  logic [7:0] ch,
    input  logic       is_last,
    output logic       done,
    output logic       matched
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequence each transfer and the evaluation that follows a question end
    lqm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .is_last  (is_last),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .matched  (matched)
    );

    // hold label, chain tables and question buffer
    lqm_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .ch      (ch),
        .is_last (is_last),
        .status  (status)
    );

endmodule

// File: rtl/lqm_dp.sv
// ---------------------------------------------------------------------------
// lqm_dp
// Datapath: label, link and question memories, evaluation registers.
// ---------------------------------------------------------------------------
module lqm_dp import lqm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic [7:0] ch,
    input  logic       is_last,
    output dp_status_t status
);

    logic [7:0]    label_mem [ML];
    logic [PW:0]   next_mem  [ML];
    logic [PW-1:0] first_mem [CV];
    logic [PW-1:0] tail_mem  [CV];
    logic [7:0]    q_mem     [QD];

    logic [LW-1:0]  lbl_len_reg;
    logic           label_open_reg;
    logic [7:0]     prev_reg;
    logic [CV-1:0]  fv_reg;
    logic [PW-1:0]  pos_reg;
    logic [CW-1:0]  c_link_reg;
    logic           link_reg;
    logic [QW-1:0]  qlen_reg;
    logic           ovf_reg;

    logic [QW-1:0]  start_reg;
    logic [QW-1:0]  n_reg;
    logic [LW-1:0]  ls_reg;
    logic [LW-1:0]  k_reg;
    logic [PW-1:0]  j_reg;
    logic           hasj_reg;
    logic [CW-1:0]  c_reg;
    logic           prefix_reg;
    logic           suffix_reg;

    logic [7:0]     q_rd_reg;
    logic [7:0]     l_rd_reg;
    logic [PW:0]    next_rd_reg;
    logic [PW-1:0]  first_rd_reg;
    logic [PW-1:0]  tail_rd_reg;

    logic [LW-1:0]  eff_len;
    logic [7:0]     eff_prev;
    logic           room;
    logic           chain;
    logic           lbl_acc;
    logic           do_link;
    logic [QAW-1:0] q_raddr;
    logic [PW-1:0]  l_raddr;
    logic [CW-1:0]  f_raddr;
    logic           nx_we;
    logic [PW-1:0]  nx_waddr;
    logic [PW:0]    nx_wdata;
    logic [LW-1:0]  j_ext;

    assign lbl_acc  = (cmd.op == OP_LBL_ACC);
    assign do_link  = (cmd.op == OP_LINK) && link_reg;
    assign eff_len  = label_open_reg ? lbl_len_reg : '0;
    assign eff_prev = label_open_reg ? prev_reg : 8'd0;
    assign room     = (eff_len < LW'(ML));
    assign chain    = is_letter(ch) ? (eff_prev == SLASH) : !(is_digit(ch) || ch[7]);
    assign j_ext    = {1'b0, j_reg};

    always_comb
    begin
        case (cmd.op)
            OP_RD_Q0:  q_raddr = '0;
            OP_HEAD:   q_raddr = QAW'(qlen_reg - 1'b1);
            OP_CHK:    q_raddr = QAW'(start_reg);
            OP_INF:    q_raddr = QAW'(start_reg + 1'b1);
            OP_CMP_RD: q_raddr = QAW'(start_reg + QW'(k_reg));
            default:   q_raddr = '0;
        endcase
        l_raddr = PW'(ls_reg + k_reg);
        case (cmd.op)
            OP_INF:   f_raddr = q_rd_reg[CW-1:0];
            OP_SLASH: f_raddr = is_letter(q_rd_reg) ? q_rd_reg[CW-1:0] : c_reg;
            default:  f_raddr = c_reg;
        endcase
        nx_we    = 1'b0;
        nx_waddr = eff_len[PW-1:0];
        nx_wdata = '0;
        if (lbl_acc && room)
        begin
            nx_we = 1'b1;
        end
        else if (do_link && fv_reg[c_link_reg])
        begin
            nx_we    = 1'b1;
            nx_waddr = tail_rd_reg;
            nx_wdata = {1'b1, pos_reg};
        end
    end

    // memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (lbl_acc && room)
            label_mem[eff_len[PW-1:0]] <= ch;
        l_rd_reg <= label_mem[l_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
            next_mem[nx_waddr] <= nx_wdata;
        next_rd_reg <= next_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_link && !fv_reg[c_link_reg])
            first_mem[c_link_reg] <= pos_reg;
        first_rd_reg <= first_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (do_link)
            tail_mem[c_link_reg] <= pos_reg;
        tail_rd_reg <= tail_mem[ch[CW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_Q_ACC && qlen_reg < QW'(QD))
            q_mem[qlen_reg[QAW-1:0]] <= ch;
        q_rd_reg <= q_mem[q_raddr];
    end

    // label and question bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lbl_len_reg    <= '0;
            label_open_reg <= 1'b0;
            prev_reg       <= 8'd0;
            fv_reg         <= '0;
            link_reg       <= 1'b0;
            qlen_reg       <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (lbl_acc)
            begin
                if (!label_open_reg)
                    fv_reg <= '0;
                label_open_reg <= !is_last;
                if (room)
                begin
                    lbl_len_reg <= eff_len + 1'b1;
                    prev_reg    <= ch;
                    link_reg    <= chain;
                end
                else
                begin
                    lbl_len_reg <= eff_len;
                    link_reg    <= 1'b0;
                end
            end
            if (do_link)
                fv_reg[c_link_reg] <= 1'b1;
            if (cmd.op == OP_Q_ACC)
            begin
                if (qlen_reg < QW'(QD))
                    qlen_reg <= qlen_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.q_clear)
            begin
                qlen_reg <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    // evaluation registers
    always_ff @(posedge clk)
    begin
        if (lbl_acc)
        begin
            pos_reg    <= eff_len[PW-1:0];
            c_link_reg <= ch[CW-1:0];
        end
        case (cmd.op)
            OP_RD_Q0:
            begin
                start_reg <= '0;
                n_reg     <= qlen_reg;
            end
            OP_HEAD:
            begin
                prefix_reg <= (q_rd_reg != STAR);
                if (q_rd_reg == STAR)
                begin
                    start_reg <= QW'(1);
                    n_reg     <= n_reg - 1'b1;
                end
            end
            OP_TAIL:
            begin
                suffix_reg <= (q_rd_reg != STAR);
                if (q_rd_reg == STAR)
                    n_reg <= n_reg - 1'b1;
            end
            OP_CHK:
            begin
                ls_reg <= prefix_reg ? '0 : LW'(lbl_len_reg - LW'(n_reg));
                k_reg  <= '0;
            end
            OP_INF:
            begin
                c_reg    <= q_rd_reg[CW-1:0];
                hasj_reg <= fv_reg[q_rd_reg[CW-1:0]];
            end
            OP_SLASH:
            begin
                if (is_letter(q_rd_reg))
                begin
                    start_reg <= start_reg + 1'b1;
                    n_reg     <= n_reg - 1'b1;
                    hasj_reg  <= fv_reg[q_rd_reg[CW-1:0]];
                end
            end
            OP_FIRST:   j_reg <= first_rd_reg;
            OP_WALK:
            begin
                ls_reg <= j_ext;
                k_reg  <= '0;
            end
            OP_CMP_CHK: k_reg <= k_reg + 1'b1;
            OP_NEXT:
            begin
                hasj_reg <= next_rd_reg[PW];
                j_reg    <= next_rd_reg[PW-1:0];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        status.q_empty   = ovf_reg || (qlen_reg == '0);
        status.q_star    = (q_rd_reg == STAR);
        status.n_one     = (n_reg == QW'(1));
        status.n_gt_one  = (n_reg > QW'(1));
        status.n_gt_len  = (n_reg > QW'(lbl_len_reg));
        status.prefix    = prefix_reg;
        status.suffix    = suffix_reg;
        status.q_high    = q_rd_reg[7];
        status.q_slash   = (q_rd_reg == SLASH);
        status.walk_stop = !hasj_reg || (j_ext >= lbl_len_reg)
                           || (QW'(lbl_len_reg - j_ext) < n_reg);
        status.cmp_eq    = (q_rd_reg == l_rd_reg);
        status.cmp_last  = (QW'(k_reg + 1'b1) == n_reg);
    end

endmodule

// File: rtl/lqm_ctrl.sv
// ---------------------------------------------------------------------------
// lqm_ctrl
// Controller: sequences loading, link insertion and match evaluation.
// ---------------------------------------------------------------------------
module lqm_ctrl import lqm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       req_type,
    input  logic       is_last,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done,
    output logic       matched
);

    state_t state_reg, state_next;
    logic   walk_reg, walk_next;
    logic   done_reg, done_next;
    logic   matched_reg, matched_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            walk_reg    <= 1'b0;
            done_reg    <= 1'b0;
            matched_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            done_reg    <= done_next;
            matched_reg <= matched_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        done_next    = 1'b0;
        matched_next = matched_reg;
        cmd.op       = OP_NONE;
        cmd.q_clear  = 1'b0;
        busy         = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (!req_type)
                    begin
                        cmd.op     = OP_LBL_ACC;
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        cmd.op = OP_Q_ACC;
                        if (is_last)
                            state_next = ST_START;
                    end
                end
            end
            ST_LINK:
            begin
                cmd.op     = OP_LINK;
                state_next = ST_IDLE;
            end
            ST_START:
            begin
                if (status.q_empty)
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b0;
                    cmd.q_clear  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_RD_Q0;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD, ST_TAIL:
            begin
                // a lone star (or two) matches anything
                if (status.q_star && status.n_one)
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b1;
                    cmd.q_clear  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (state_reg == ST_HEAD)
                begin
                    cmd.op     = OP_HEAD;
                    state_next = ST_TAIL;
                end
                else
                begin
                    cmd.op     = OP_TAIL;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (status.n_gt_len)
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b0;
                    cmd.q_clear  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_CHK;
                    walk_next  = 1'b0;
                    state_next = (status.prefix || status.suffix) ? ST_CMP_RD : ST_INF;
                end
            end
            ST_INF:
            begin
                if (status.q_high)
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b0;
                    cmd.q_clear  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_INF;
                    state_next = (status.q_slash && status.n_gt_one) ? ST_SLASH : ST_FIRST;
                end
            end
            ST_SLASH:
            begin
                cmd.op     = OP_SLASH;
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                cmd.op     = OP_FIRST;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.walk_stop)
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b0;
                    cmd.q_clear  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_WALK;
                    walk_next  = 1'b1;
                    state_next = ST_CMP_RD;
                end
            end
            ST_CMP_RD:
            begin
                cmd.op     = OP_CMP_RD;
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK:
            begin
                if (status.cmp_eq && status.cmp_last)
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b1;
                    cmd.q_clear  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (status.cmp_eq)
                begin
                    cmd.op     = OP_CMP_CHK;
                    state_next = ST_CMP_RD;
                end
                else if (walk_reg)
                begin
                    cmd.op     = OP_CMP_CHK;
                    state_next = ST_NEXT;
                end
                else
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b0;
                    cmd.q_clear  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_NEXT:
            begin
                cmd.op     = OP_NEXT;
                state_next = ST_WALK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done    = done_reg;
    assign matched = matched_reg;

endmodule

// File: rtl/lqm_check.sv
// ---------------------------------------------------------------------------
// lqm_check
// Port-level checks of the matcher's transfer sequencing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lqm_check
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic req_type,
    input logic is_last,
    input logic done
);

    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `ASSERT_NEXT(a_label_quiet, clk, rst_n, start && !busy && !req_type, !done && busy)
    `ASSERT_NEXT(a_qchar_quiet, clk, rst_n, start && !busy && req_type && !is_last, !done && !busy)
    `ASSERT_NEXT(a_qend_eval, clk, rst_n, start && !busy && req_type && is_last, busy && !done)

endmodule

bind label_question_matcher lqm_check u_lqm_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .is_last  (is_last),
    .done     (done)
);

// File: tb/sv/tb_label_question_matcher.sv
// ---------------------------------------------------------------------------
// tb_label_question_matcher
// Self-checking bench: streams labels and wildcard questions, predicts matches.
// ---------------------------------------------------------------------------
module tb_label_question_matcher;
    import lqm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Request kinds carried on req_type
    localparam logic REQ_LABEL    = 1'b0;
    localparam logic REQ_QUESTION = 1'b1;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       req_type;
    logic [7:0] ch;
    logic       is_last;
    logic       done;
    logic       matched;

    int         fail_count;

    label_question_matcher i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .ch       (ch),
        .is_last  (is_last),
        .done     (done),
        .matched  (matched)
    );

    always #5 clk = ~clk;

    // Generous wall: worst walks over a full label dominate.
    initial
    begin
        #500ms;
        $display("FAILURE");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Predictor state: a private copy of the label store, the per-character
    // chains and the question buffer.
    // -----------------------------------------------------------------------
    logic [7:0]    lbl_mem [ML];
    int            lbl_len;
    int            head_pos [CV];
    bit            head_ok  [CV];
    int            link_pos [ML];
    bit            link_ok  [ML];
    int            tail_pos [CV];
    logic [7:0]    prev_byte;
    logic [7:0]    q_mem [QD];
    int            q_len;
    bit            q_ovf;
    bit            lbl_open;

    bit            match_q[$];   // matches still owed by the block

    function automatic bit letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    // Append a position to the chain of its character value.
    task automatic chain_append(input int pos, input logic [7:0] c);
        int idx;
        idx = int'(c[6:0]);
        if (!head_ok[idx])
        begin
            head_pos[idx] = pos;
            head_ok[idx]  = 1'b1;
        end
        else
        begin
            link_pos[tail_pos[idx]] = pos;
            link_ok[tail_pos[idx]]  = 1'b1;
        end
        tail_pos[idx] = pos;
    endtask

    function automatic bit bytes_equal(input int qs, input int ls, input int n);
        for (int k = 0; k < n; k++)
        begin
            if (qs + k >= QD || ls + k >= ML)
                return 1'b0;
            if (q_mem[qs + k] != lbl_mem[ls + k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Wildcard match of the buffered question against the stored label.
    function automatic bit wildcard_match();
        int         st;
        int         n;
        int         j;
        bit         has_j;
        bit         anchored_front;
        bit         anchored_back;
        logic [7:0] c;
        st = 0;
        n  = q_len;
        if (q_ovf || n == 0)
            return 1'b0;
        anchored_front = q_mem[0] != STAR;
        if (!anchored_front)
        begin
            st = 1;
            n--;
            if (n == 0)
                return 1'b1;
        end
        anchored_back = q_mem[st + n - 1] != STAR;
        if (!anchored_back)
        begin
            n--;
            if (n == 0)
                return 1'b1;
        end
        if (n > lbl_len)
            return 1'b0;
        if (anchored_front)
            return bytes_equal(st, 0, n);
        if (anchored_back)
            return bytes_equal(st, lbl_len - n, n);
        c = q_mem[st];
        if (c >= 8'd128)
            return 1'b0;
        // drop a leading slash in front of a letter
        if (c == SLASH && n > 1 && letter(q_mem[st + 1]))
        begin
            st++;
            n--;
            c = q_mem[st];
        end
        has_j = head_ok[c[6:0]];
        j     = head_pos[c[6:0]];
        for (int steps = 0; has_j && steps < ML; steps++)
        begin
            if (j >= ML || j >= lbl_len)
                return 1'b0;
            if (lbl_len - j < n)
                return 1'b0;
            if (bytes_equal(st, j, n))
                return 1'b1;
            has_j = link_ok[j];
            j     = link_pos[j];
        end
        return 1'b0;
    endfunction

    // Advance the predictor by one accepted transfer.
    task automatic predict_transfer(input logic rt, input logic [7:0] c, input logic last);
        int pos;
        if (rt == REQ_LABEL)
        begin
            if (!lbl_open)
            begin
                lbl_len   = 0;
                prev_byte = 8'd0;
                lbl_open  = 1'b1;
                foreach (head_ok[i])
                    head_ok[i] = 1'b0;
            end
            if (lbl_len < ML)
            begin
                pos          = lbl_len;
                lbl_mem[pos] = c;
                link_ok[pos] = 1'b0;
                if (letter(c))
                begin
                    if (prev_byte == SLASH)
                        chain_append(pos, c);
                end
                else if (!((c >= 8'd48 && c <= 8'd57) || c >= 8'd128))
                    chain_append(pos, c);
                prev_byte = c;
                lbl_len   = pos + 1;
            end
            if (last)
                lbl_open = 1'b0;
        end
        else
        begin
            if (q_len < QD)
            begin
                q_mem[q_len] = c;
                q_len++;
            end
            else
                q_ovf = 1'b1;
            if (last)
            begin
                match_q.push_back(wildcard_match());
                q_len = 0;
                q_ovf = 1'b0;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Driver
    // -----------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Send one transfer; start stays high afterwards for back-to-back items.
    task automatic send_item(input logic rt, input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= rt;
        ch       <= c;
        is_last  <= last;
        do
            @(posedge clk);
        while (busy);
        predict_transfer(rt, c, last);
    endtask

    task automatic send_string(input logic rt, input logic [7:0] s[$]);
        foreach (s[i])
            send_item(rt, s[i], i == s.size() - 1);
    endtask

    function automatic void to_bytes(input string txt, output logic [7:0] s[$]);
        s = {};
        for (int i = 0; i < txt.len(); i++)
            s.push_back(txt[i]);
    endfunction

    task automatic send_text(input logic rt, input string txt);
        logic [7:0] s[$];
        to_bytes(txt, s);
        send_string(rt, s);
    endtask

    // Hold the sender until every owed result is back.
    task automatic drain_results();
        start <= 1'b0;
        while (match_q.size() != 0)
            @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Checker: done is a single-cycle strobe, sampled at the edge ending it.
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        bit want;
        if (rst_n && done)
        begin
            if (match_q.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = match_q.pop_front();
                if (matched !== want)
                    report_mismatch($sformatf("matched=%b, expected %b", matched, want));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_basic_wildcards();
        send_text(REQ_LABEL, "ab/cd-e.f/x");
        send_text(REQ_QUESTION, "*");
        send_text(REQ_QUESTION, "**");
        send_text(REQ_QUESTION, "ab/*");
        send_text(REQ_QUESTION, "*.f/x");
        send_text(REQ_QUESTION, "*-e*");
        send_text(REQ_QUESTION, "*/cd*");
        send_text(REQ_QUESTION, "*cd*");
        send_text(REQ_QUESTION, "*/x*");
        send_text(REQ_QUESTION, "zz*");
        send_text(REQ_QUESTION, "ab/cd-e.f/x");
        send_text(REQ_QUESTION, "ab/cd-e.f/xy");
    endtask

    // Zero, high bytes and digits: stored but not all chained.
    task automatic test_odd_bytes();
        logic [7:0] s[$];
        s = '{8'h00, 8'hFF, 8'd45, 8'h80, 8'd55, 8'd47, 8'd65, 8'h00};
        send_string(REQ_LABEL, s);
        s = '{STAR, 8'hFF, 8'd45, STAR};
        send_string(REQ_QUESTION, s);
        s = '{STAR, 8'd45, 8'h80, 8'd55, STAR};
        send_string(REQ_QUESTION, s);
        s = '{STAR, 8'h00};
        send_string(REQ_QUESTION, s);
        s = '{8'h00, STAR};
        send_string(REQ_QUESTION, s);
        s = '{STAR, 8'd47, 8'd65, STAR};
        send_string(REQ_QUESTION, s);
    endtask

    // Question asked while the label is still open.
    task automatic test_open_label();
        send_item(REQ_LABEL, "q", 1'b0);
        send_item(REQ_LABEL, "-", 1'b0);
        send_text(REQ_QUESTION, "q-*");
        send_text(REQ_QUESTION, "*-*");
        send_item(REQ_LABEL, "r", 1'b1);
        send_text(REQ_QUESTION, "*-r");
    endtask

    // Truncated label and overflowing question.
    task automatic test_long_strings();
        logic [7:0] s[$];
        s = {};
        for (int i = 0; i < ML + 20; i++)
            s.push_back((i % 7 == 3) ? 8'd46 : 8'(97 + i % 5));
        send_string(REQ_LABEL, s);
        send_text(REQ_QUESTION, "*.*");
        send_text(REQ_QUESTION, "*ed");
        s = {};
        for (int i = 0; i < QD + 3; i++)
            s.push_back(8'd97);
        send_string(REQ_QUESTION, s);
        send_text(REQ_QUESTION, "abc*");
        drain_results();
    endtask

    function automatic logic [7:0] rand_byte();
        string letters;
        string marks;
        int    r;
        letters = "abAB";
        marks   = "/-.*";
        r = $urandom_range(99);
        if (r < 30)
            return letters[$urandom_range(3)];
        if (r < 50)
            return marks[$urandom_range(3)];
        if (r < 60)
            return ($urandom_range(1) == 0) ? 8'd48 : 8'd57;
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed labels with questions cut from them.
    task automatic test_random_traffic(input int budget);
        logic [7:0] s[$];
        int         len;
        int         a;
        int         l;
        int         form;
        int         sent;
        sent = 0;
        while (sent < budget)
        begin
            len = ($urandom_range(99) < 2) ? $urandom_range(ML + 8, ML - 8)
                                           : $urandom_range(24, 1);
            s = {};
            for (int i = 0; i < len; i++)
                s.push_back(rand_byte());
            send_string(REQ_LABEL, s);
            sent += len;
            repeat ($urandom_range(5, 1))
            begin
                s = {};
                form = $urandom_range(9);
                if (form < 7 && lbl_len > 0)
                begin
                    l = $urandom_range((lbl_len < 8) ? lbl_len : 8, 1);
                    a = $urandom_range(lbl_len - l);
                    if (form < 2)
                        a = 0;
                    else if (form < 4)
                        a = lbl_len - l;
                    for (int i = 0; i < l; i++)
                        s.push_back(lbl_mem[a + i]);
                    if ($urandom_range(4) == 0)
                        s[$urandom_range(l - 1)] = rand_byte();
                    if (form >= 2)
                        s.push_front(STAR);
                    if (form < 2 || form >= 4)
                        s.push_back(STAR);
                end
                else
                begin
                    for (int i = 0; i < $urandom_range(6, 1); i++)
                        s.push_back(rand_byte());
                end
                send_string(REQ_QUESTION, s);
                sent += s.size();
            end
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_LABEL;
        ch         = 8'd0;
        is_last    = 1'b0;
        fail_count = 0;
        lbl_len    = 0;
        prev_byte  = 8'd0;
        q_len      = 0;
        q_ovf      = 1'b0;
        lbl_open   = 1'b0;
        foreach (head_ok[i])
            head_ok[i] = 1'b0;
        foreach (link_ok[i])
            link_ok[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_wildcards();
        test_odd_bytes();
        test_open_label();
        test_long_strings();
        test_random_traffic(200);

        start <= 1'b0;
        while (match_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
